/* src/hft_pkg.sv */
// ============================================================================
// hft_pkg
// Shared types, constants and FCS-16 helper for the HDLC frame transmitter.
// ============================================================================
package hft_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] PF_BIT    = 8'h10;

    localparam logic [15:0] FCS_INIT = 16'hFFFF;
    localparam logic [15:0] FCS_POLY = 16'h8408;

    // Frame type codes
    localparam logic [3:0] FT_I    = 4'd0;
    localparam logic [3:0] FT_RR   = 4'd1;
    localparam logic [3:0] FT_RNR  = 4'd2;
    localparam logic [3:0] FT_REJ  = 4'd3;
    localparam logic [3:0] FT_SREJ = 4'd4;
    localparam logic [3:0] FT_UI   = 4'd5;
    localparam logic [3:0] FT_SABM = 4'd6;
    localparam logic [3:0] FT_DISC = 4'd7;
    localparam logic [3:0] FT_UA   = 4'd8;
    localparam logic [3:0] FT_CMDR = 4'd9;
    localparam logic [3:0] FT_TEST = 4'd10;

    // Item kinds
    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    localparam int unsigned SLOTS = 6;

    // One logical line byte before stuffing
    typedef struct packed {
        logic [7:0] data;
        logic       stuff;   // subject to byte stuffing
        logic       done;    // closing flag
    } slot_t;

    // Logical bytes caused by one item
    typedef struct packed {
        slot_t [SLOTS-1:0] slot;
        logic  [2:0]       count;
    } job_t;

    function automatic slot_t mk_slot(input logic [7:0] data, input logic stuff,
                                      input logic done);
        slot_t s;
        s.data  = data;
        s.stuff = stuff;
        s.done  = done;
        return s;
    endfunction

    // Bitwise FCS-16 update over one byte (reflected)
    function automatic logic [15:0] fcs_byte(input logic [15:0] f_in,
                                             input logic [7:0] b);
        logic [15:0] f;
        f = f_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
        end
        return f;
    endfunction

endpackage

/* src/hft_build.sv */
// ============================================================================
// hft_build
// Frame state and FCS; turns an accepted item into a list of logical bytes.
// ============================================================================
module hft_build
    import hft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       cmd,
    input  logic [3:0] frame_type,
    input  logic [2:0] send_seq,
    input  logic [2:0] recv_seq,
    input  logic       poll_final,
    input  logic [7:0] station_address,
    input  logic [7:0] payload_byte,
    input  logic       frame_last,
    input  logic       job_take,
    output logic       job_valid,
    output job_t       job
);

    logic [15:0] fcs_reg, fcs_next;
    logic        open_reg, open_next;
    logic        allowed_reg, allowed_next;
    logic        job_valid_reg, job_valid_next;
    job_t        job_reg, job_next;

    logic [7:0]  ctrl;
    logic        type_ok;
    logic        carries;
    logic [15:0] f_hdr;
    logic [15:0] f_pay;
    logic [15:0] fcs_out;
    slot_t       s_lo, s_hi, s_flag;

    // Control byte decode
    always_comb
    begin
        ctrl    = 8'h00;
        type_ok = 1'b1;
        carries = 1'b0;
        unique case (frame_type)
            FT_I:
            begin
                ctrl    = {recv_seq, 1'b0, send_seq, 1'b0};
                carries = 1'b1;
            end
            FT_RR:   ctrl = {recv_seq, 5'h01};
            FT_RNR:  ctrl = {recv_seq, 5'h05};
            FT_REJ:  ctrl = {recv_seq, 5'h09};
            FT_SREJ: ctrl = {recv_seq, 5'h0D};
            FT_UI:
            begin
                ctrl    = 8'h03;
                carries = 1'b1;
            end
            FT_SABM: ctrl = 8'h2F;
            FT_DISC: ctrl = 8'h43;
            FT_UA:   ctrl = 8'h63;
            FT_CMDR: ctrl = 8'h83;
            FT_TEST: ctrl = 8'hE3;
            default: type_ok = 1'b0;
        endcase
        if (poll_final)
        begin
            ctrl = ctrl | PF_BIT;
        end
    end

    assign f_hdr   = fcs_byte(fcs_byte(FCS_INIT, station_address), ctrl);
    assign f_pay   = allowed_reg ? fcs_byte(fcs_reg, payload_byte) : fcs_reg;
    assign fcs_out = ~((cmd == CMD_HEADER) ? f_hdr : f_pay);
    assign s_lo    = mk_slot(fcs_out[7:0], 1'b1, 1'b0);
    assign s_hi    = mk_slot(fcs_out[15:8], 1'b1, 1'b0);
    assign s_flag  = mk_slot(FLAG_BYTE, 1'b0, 1'b1);

    always_comb
    begin
        fcs_next       = fcs_reg;
        open_next      = open_reg;
        allowed_next   = allowed_reg;
        job_next       = '0;
        job_valid_next = job_valid_reg;

        if (cmd == CMD_HEADER)
        begin
            job_next.slot[0] = mk_slot(FLAG_BYTE, 1'b0, 1'b0);
            job_next.slot[1] = mk_slot(station_address, 1'b1, 1'b0);
            job_next.slot[2] = mk_slot(ctrl, 1'b1, 1'b0);
            job_next.slot[3] = s_lo;
            job_next.slot[4] = s_hi;
            job_next.slot[5] = s_flag;
            job_next.count   = frame_last ? 3'd6 : 3'd3;
            if (!type_ok)
            begin
                job_next.count = 3'd0;
            end
        end
        else if (open_reg)
        begin
            if (allowed_reg)
            begin
                job_next.slot[0] = mk_slot(payload_byte, 1'b1, 1'b0);
                job_next.slot[1] = s_lo;
                job_next.slot[2] = s_hi;
                job_next.slot[3] = s_flag;
                job_next.count   = frame_last ? 3'd4 : 3'd1;
            end
            else
            begin
                job_next.slot[0] = s_lo;
                job_next.slot[1] = s_hi;
                job_next.slot[2] = s_flag;
                job_next.count   = frame_last ? 3'd3 : 3'd0;
            end
        end

        if (accept)
        begin
            if (cmd == CMD_HEADER)
            begin
                if (type_ok)
                begin
                    open_next    = !frame_last;
                    allowed_next = carries && !frame_last;
                    fcs_next     = frame_last ? FCS_INIT : f_hdr;
                end
            end
            else if (open_reg)
            begin
                if (frame_last)
                begin
                    open_next    = 1'b0;
                    allowed_next = 1'b0;
                    fcs_next     = FCS_INIT;
                end
                else
                begin
                    fcs_next = f_pay;
                end
            end
        end

        if (accept && (job_next.count != 3'd0))
        begin
            job_valid_next = 1'b1;
        end
        else if (job_take)
        begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcs_reg       <= FCS_INIT;
            open_reg      <= 1'b0;
            allowed_reg   <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            fcs_reg       <= fcs_next;
            open_reg      <= open_next;
            allowed_reg   <= allowed_next;
            job_valid_reg <= job_valid_next;
        end
    end

    // Job register: loads only with a new job
    always_ff @(posedge clk)
    begin
        if (accept && (job_next.count != 3'd0))
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

/* src/hft_serial.sv */
// ============================================================================
// hft_serial
// Walks a job's logical bytes, applies byte stuffing, drives the output item.
// ============================================================================
module hft_serial
    import hft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       escape_enable,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_take,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       frame_done
);

    logic [2:0] pos_reg, pos_next;
    logic       half_reg, half_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       done_reg;

    slot_t      cur;
    logic       esc;
    logic       emit;
    logic       slot_end;
    logic       job_end;
    logic [7:0] byte_now;

    assign cur      = job.slot[pos_reg];
    assign esc      = escape_enable && cur.stuff
                      && ((cur.data == ESC_BYTE) || (cur.data == FLAG_BYTE));
    assign emit     = job_valid && (!out_valid_reg || out_ready);
    assign slot_end = !esc || half_reg;
    assign job_end  = slot_end && (pos_reg == (job.count - 3'd1));
    assign byte_now = !esc ? cur.data : (half_reg ? (cur.data ^ ESC_XOR) : ESC_BYTE);

    always_comb
    begin
        pos_next       = pos_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (job_end)
            begin
                pos_next  = 3'd0;
                half_next = 1'b0;
            end
            else if (slot_end)
            begin
                pos_next  = pos_reg + 3'd1;
                half_next = 1'b0;
            end
            else
            begin
                half_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 3'd0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= byte_now;
            last_reg <= job_end;
            done_reg <= cur.done;
        end
    end

    assign job_take   = emit && job_end;
    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = last_reg;
    assign frame_done = done_reg;

endmodule

/* src/hdlc_frame_transmitter_top.sv */
// ============================================================================
// hdlc_frame_transmitter_top
// HDLC transmit framer: flags, address, control, payload, FCS-16, stuffing.
// ============================================================================
//
//  Channel | Direction | Handshake            | Item
//  --------+-----------+----------------------+------------------------------------
//  in      | in        | in_valid / in_ready  | header or payload byte, frame_last
//  out     | out       | out_valid/out_ready  | out_byte, run_last, frame_done
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_data = escape_enable
//
//  One line byte leaves per cycle while a job is pending and out_ready is not
//  held low. An item causes 1-2 line bytes for a payload byte, 4-7 for a
//  payload byte that closes the frame (3-5 if the byte is dropped), 3-5 for a
//  header, up to 10 for a header that also closes the frame. Items causing no
//  byte are taken without creating a job. The next item is accepted in the
//  cycle the current one's last byte enters the output register, so there
//  is no gap between items. Reset is asynchronous, active low: no frame open,
//  FCS at 0xFFFF, stuffing enabled. Stalls on out_ready hold the output item
//  and back-pressure in_ready once the pending job is full.
//
module hdlc_frame_transmitter_top
    import hft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    // input items
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [3:0] frame_type,
    input  logic [2:0] send_seq,
    input  logic [2:0] recv_seq,
    input  logic       poll_final,
    input  logic [7:0] station_address,
    input  logic [7:0] payload_byte,
    input  logic       frame_last,
    // result items
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       frame_done
);

    logic esc_en_reg;
    logic job_valid;
    logic job_take;
    logic accept;
    job_t job;

    // The user must write configuration only when idle; the block does not enforce it, so always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            esc_en_reg <= cfg_data;
        end
    end

    // Pending job slot free, or emptied this cycle
    assign in_ready = !job_valid || job_take;
    assign accept   = in_valid && in_ready;

    hft_build u_build (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .cmd             (cmd),
        .frame_type      (frame_type),
        .send_seq        (send_seq),
        .recv_seq        (recv_seq),
        .poll_final      (poll_final),
        .station_address (station_address),
        .payload_byte    (payload_byte),
        .frame_last      (frame_last),
        .job_take        (job_take),
        .job_valid       (job_valid),
        .job             (job)
    );

    hft_serial u_serial (
        .clk           (clk),
        .rst_n         (rst_n),
        .escape_enable (esc_en_reg),
        .job_valid     (job_valid),
        .job           (job),
        .job_take      (job_take),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .frame_done    (frame_done)
    );

endmodule
